[hdl/cfl_pkg.sv]
// cfl_pkg: shared constants, types and helper functions of the calibrated fir lowpass unit
// no dependencies; imported by the interfaces, cfl_regs, cfl_mac and the top level

package cfl_pkg;

  // filter geometry
  localparam int TAPS       = 11;
  localparam int FRAC_BITS  = 16;
  localparam int NCOEF      = 6;
  localparam int HIST_DEPTH = TAPS - 1;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int COEF_SEL_W = $clog2(NCOEF);

  // field widths
  localparam int SAMPLE_W  = 32;
  localparam int GAIN_W    = 32;
  localparam int GAIN_HALF = GAIN_W / 2;
  localparam int COEF_W    = 18;
  localparam int WEIGHT_W  = 40;
  localparam int DIFF_W    = SAMPLE_W + 1;

  // shared multiplier and accumulator
  localparam int MUL_A_W = WEIGHT_W + 1;
  localparam int MUL_B_W = COEF_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = DIFF_W + GAIN_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfl_reg_idx_t;

  // register indexes
  localparam cfl_reg_idx_t REG_ZERO_OFFSET = CFG_IDX_W'(0);
  localparam cfl_reg_idx_t REG_GAIN        = CFG_IDX_W'(1);
  localparam cfl_reg_idx_t REG_COEF_OUTER  = CFG_IDX_W'(2);
  localparam cfl_reg_idx_t REG_COEF_CENTER = CFG_IDX_W'(7);

  // reset values of the registers
  localparam logic signed [SAMPLE_W-1:0] ZERO_OFFSET_RESET = SAMPLE_W'(39149384);
  localparam logic [GAIN_W-1:0]          GAIN_RESET        = GAIN_W'(442679);
  localparam logic [NCOEF-1:0][COEF_W-1:0] COEF_RESET = '{
    0: COEF_W'(0),
    1: COEF_W'(-204),
    2: COEF_W'(-839),
    3: COEF_W'(3194),
    4: COEF_W'(17220),
    5: COEF_W'(26794)
  };

  // register file contents
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]     zero_offset;
    logic [GAIN_W-1:0]              gain;
    logic [NCOEF-1:0][COEF_W-1:0]   coef;
  } cfl_cfg_t;

  // multiply-accumulate command
  typedef struct packed {
    logic issue;
    logic clear;
    logic shift_hi;
  } cfl_mac_ctl_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CAL0,
    S_CAL1,
    S_CAL2,
    S_WGT,
    S_TAP,
    S_DRAIN,
    S_FIN
  } cfl_state_t;

  // coefficient register for tap k: mirrored distance from the ends, capped at the center
  function automatic logic [COEF_SEL_W-1:0] tap_coef_sel(input logic [TAP_W-1:0] k);
    logic [TAP_W-1:0] m;
    logic [TAP_W-1:0] d;
    m = TAP_W'(TAPS - 1) - k;
    d = (k < m) ? k : m;
    if (d > TAP_W'(NCOEF - 1)) begin
      d = TAP_W'(NCOEF - 1);
    end
    return COEF_SEL_W'(d);
  endfunction

endpackage

[hdl/cfl_in_if.sv]
// cfl_in_if: input item channel (adc sample and record start flag)
// depends on cfl_pkg

interface cfl_in_if;
  import cfl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] adc_sample;
  logic                       first_of_record;

  modport source (output valid, output adc_sample, output first_of_record, input ready);
  modport sink   (input valid, input adc_sample, input first_of_record, output ready);
endinterface

[hdl/cfl_out_if.sv]
// cfl_out_if: result item channel (calibrated and filtered weight)
// depends on cfl_pkg

interface cfl_out_if;
  import cfl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] calibrated_weight;
  logic signed [WEIGHT_W-1:0] filtered_weight;

  modport source (output valid, output calibrated_weight, output filtered_weight, input ready);
  modport sink   (input valid, input calibrated_weight, input filtered_weight, output ready);
endinterface

[hdl/cfl_cfg_if.sv]
// cfl_cfg_if: configuration write channel (register index and write data)
// depends on cfl_pkg

interface cfl_cfg_if;
  import cfl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[hdl/cfl_ram.sv]
// cfl_ram: generic single-write, single-read ram with registered read data
// no dependencies

module cfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/cfl_regs.sv]
// cfl_regs: configuration register file (zero offset, gain, six coefficients)
// depends on cfl_pkg and cfl_cfg_if

module cfl_regs (
  input  logic              clk,
  input  logic              rst_n,
  cfl_cfg_if.sink           cfg_ch,
  output cfl_pkg::cfl_cfg_t cfg
);
  import cfl_pkg::*;

  logic signed [SAMPLE_W-1:0]   zero_offset_r;
  logic [GAIN_W-1:0]            gain_r;
  logic [NCOEF-1:0][COEF_W-1:0] coef_r;
  logic [COEF_SEL_W-1:0]        coef_idx;
  logic                         wr_en;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign coef_idx     = COEF_SEL_W'(cfg_ch.reg_index - REG_COEF_OUTER);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= ZERO_OFFSET_RESET;
      gain_r        <= GAIN_RESET;
      coef_r        <= COEF_RESET;
    end else if (wr_en) begin
      if (cfg_ch.reg_index == REG_ZERO_OFFSET) begin
        zero_offset_r <= $signed(cfg_ch.wdata[SAMPLE_W-1:0]);
      end else if (cfg_ch.reg_index == REG_GAIN) begin
        gain_r <= cfg_ch.wdata[GAIN_W-1:0];
      end else if (cfg_ch.reg_index inside {[REG_COEF_OUTER:REG_COEF_CENTER]}) begin
        coef_r[coef_idx] <= cfg_ch.wdata[COEF_W-1:0];
      end
    end
  end

  assign cfg.zero_offset = zero_offset_r;
  assign cfg.gain        = gain_r;
  assign cfg.coef        = coef_r;

endmodule

[hdl/cfl_mac.sv]
// cfl_mac: shared multiplier with registered product, accumulator and q.16 saturating output
// depends on cfl_pkg

module cfl_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cfl_pkg::cfl_mac_ctl_t                 ctl,
  input  logic signed [cfl_pkg::MUL_A_W-1:0]    op_a,
  input  logic signed [cfl_pkg::MUL_B_W-1:0]    op_b,
  output logic signed [cfl_pkg::WEIGHT_W-1:0]   result
);
  import cfl_pkg::*;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  logic signed [PROD_W-1:0]  prod_r;
  cfl_mac_ctl_t              ctl_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-WEIGHT_W:0]   upper;

  // multiply stage
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  // accumulate stage, high gain half weighted by 2^16
  always_comb begin
    addend  = ctl_r.shift_hi ? (ACC_W'(prod_r) <<< GAIN_HALF) : ACC_W'(prod_r);
    acc_nxt = (ctl_r.clear ? '0 : acc_r) + addend;
  end

  always_ff @(posedge clk) begin
    if (ctl_r.issue) begin
      acc_r <= acc_nxt;
    end
  end

  // floor shift and saturate to 40 bits
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    upper   = shifted[ACC_W-1:WEIGHT_W-1];
    if ((&upper) || (~|upper)) begin
      result = shifted[WEIGHT_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = W_MIN;
    end else begin
      result = W_MAX;
    end
  end

endmodule

[hdl/calibrated_fir_lowpass_unit.sv]
// calibrated_fir_lowpass_unit: load cell calibration and symmetric fir lowpass, top level
// depends on cfl_pkg, cfl_in_if, cfl_out_if, cfl_cfg_if, cfl_regs, cfl_mac, cfl_ram
//
// usage:
//   in_ch takes one item per sample: signed adc_sample and first_of_record.
//   out_ch gives one item per input: calibrated_weight and filtered_weight, q.16.
//   cfg_ch writes registers by index (zero offset, gain, six coefficients); it is
//   always ready and should be written only while no item is in flight.
// sequence:
//   one item at a time: a new item is accepted only once the last one has loaded its
//   result into the output register. the steps are set by the single shared multiplier:
//   the accept step, two passes for the calibration product (S_CAL0, S_CAL1), waits
//   on the product and accumulator registers (S_CAL2, S_WGT), one pass per tap, then
//   S_DRAIN and S_FIN, of which the last loads the result.
//   the delay line lives in a 10-entry ram read one tap per cycle.
// reset:
//   registers take their default values and the delay line reads as all zero at once;
//   no clearing pass. a record start refills it by the same mechanism.
// stall:
//   the result waits in the output register while the next item is accepted and
//   processed; the block holds in its last step until the output register is free.

module calibrated_fir_lowpass_unit (
  input  logic      clk,
  input  logic      rst_n,
  cfl_in_if.sink    in_ch,
  cfl_out_if.source out_ch,
  cfl_cfg_if.sink   cfg_ch
);
  import cfl_pkg::*;

  cfl_cfg_t                   cfg;
  cfl_state_t                 st_r, st_nxt;

  logic signed [DIFF_W-1:0]   diff_r;
  logic                       first_r;
  logic signed [WEIGHT_W-1:0] weight_r;
  logic signed [WEIGHT_W-1:0] fill_r;
  logic [HIST_DEPTH-1:0]      valid_r;
  logic [HIST_AW-1:0]         wp_r;
  logic [HIST_AW-1:0]         wp_prev;
  logic [HIST_AW-1:0]         wp_next;
  logic [HIST_AW-1:0]         rd_ptr_r;
  logic [HIST_AW-1:0]         rd_ptr_prev;
  logic [HIST_AW-1:0]         rd_addr_q_r;
  logic [TAP_W-1:0]           tap_r;

  logic                       out_valid_r;
  logic signed [WEIGHT_W-1:0] out_cal_r;
  logic signed [WEIGHT_W-1:0] out_filt_r;
  logic                       out_free;

  logic                       in_rdy;
  logic                       in_take;
  logic                       fin_load;
  logic                       hist_we;
  logic [WEIGHT_W-1:0]        hist_q;
  logic signed [WEIGHT_W-1:0] hist_x;

  cfl_mac_ctl_t               mac_ctl;
  logic signed [MUL_A_W-1:0]  mac_a;
  logic signed [MUL_B_W-1:0]  mac_b;
  logic signed [WEIGHT_W-1:0] mac_result;

  // configuration registers
  cfl_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // shared multiply-accumulate unit
  cfl_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .result (mac_result)
  );

  // delay line memory, circular with write pointer
  cfl_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp_r),
    .wdata (weight_r),
    .raddr (rd_ptr_r),
    .rdata (hist_q)
  );

  // pointer arithmetic modulo the delay depth
  assign wp_prev     = (wp_r == '0) ? HIST_AW'(HIST_DEPTH - 1) : wp_r - 1'b1;
  assign wp_next     = (wp_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rd_ptr_prev = (rd_ptr_r == '0) ? HIST_AW'(HIST_DEPTH - 1) : rd_ptr_r - 1'b1;

  // entries not written since reset or record start read as the fill value
  assign hist_x   = valid_r[rd_addr_q_r] ? $signed(hist_q) : fill_r;
  assign out_free = !out_valid_r || out_ch.ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state and step outputs
  always_comb begin
    st_nxt   = st_r;
    in_rdy   = 1'b0;
    in_take  = 1'b0;
    fin_load = 1'b0;
    hist_we  = 1'b0;
    mac_ctl  = '0;
    mac_a    = '0;
    mac_b    = '0;
    case (st_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          in_take = 1'b1;
          st_nxt  = S_CAL0;
        end
      end
      S_CAL0: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a   = MUL_A_W'(diff_r);
        mac_b   = MUL_B_W'({1'b0, cfg.gain[GAIN_HALF-1:0]});
        st_nxt  = S_CAL1;
      end
      S_CAL1: begin
        mac_ctl = '{issue: 1'b1, clear: 1'b0, shift_hi: 1'b1};
        mac_a   = MUL_A_W'(diff_r);
        mac_b   = MUL_B_W'({1'b0, cfg.gain[GAIN_W-1:GAIN_HALF]});
        st_nxt  = S_CAL2;
      end
      S_CAL2: begin
        st_nxt = S_WGT;
      end
      S_WGT: begin
        st_nxt = S_TAP;
      end
      S_TAP: begin
        mac_ctl = '{issue: 1'b1, clear: (tap_r == '0), shift_hi: 1'b0};
        mac_a   = (tap_r == '0) ? MUL_A_W'(weight_r) : MUL_A_W'(hist_x);
        mac_b   = $signed(cfg.coef[tap_coef_sel(tap_r)]);
        if (tap_r == TAP_W'(TAPS - 1)) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        st_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          fin_load = 1'b1;
          hist_we  = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready = in_rdy;

  // control registers: pointers, valid bits, fill value, tap count, output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rd_ptr_r    <= '0;
      valid_r     <= '0;
      fill_r      <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        rd_ptr_r <= wp_prev;
        tap_r    <= '0;
      end
      if (st_r == S_WGT && first_r) begin
        valid_r <= '0;
        fill_r  <= mac_result;
      end
      if (st_r == S_TAP) begin
        rd_ptr_r <= rd_ptr_prev;
        tap_r    <= tap_r + 1'b1;
      end
      if (fin_load) begin
        valid_r[wp_r] <= 1'b1;
        wp_r          <= wp_next;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_q_r <= rd_ptr_r;
    if (in_take) begin
      diff_r  <= DIFF_W'(in_ch.adc_sample) - DIFF_W'(cfg.zero_offset);
      first_r <= in_ch.first_of_record;
    end
    if (st_r == S_WGT) begin
      weight_r <= mac_result;
    end
    if (fin_load) begin
      out_cal_r  <= weight_r;
      out_filt_r <= mac_result;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.calibrated_weight = out_cal_r;
  assign out_ch.filtered_weight   = out_filt_r;

  // one item in flight: no second accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous item still in work");

  // circular pointers stay inside the delay depth
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r <= HIST_AW'(HIST_DEPTH - 1)) && (rd_ptr_r <= HIST_AW'(HIST_DEPTH - 1)))
    else $error("delay line pointer out of range");

  // a finished item with a free output register produces a result and frees the block
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && !out_ch.valid) |=> (out_ch.valid && in_ch.ready))
    else $error("finished item did not reach the output register");

  // a delay line write marks its entry valid
  a_hist_valid: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |=> (valid_r[$past(wp_r)] && !hist_we))
    else $error("delay line write not marked valid");

endmodule
